@@ hdl/sms_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the segmented multi-width byte stack.
// Depends on nothing; sms_lanes and the top level refer to it by scoped names.

package sms_pkg;

   // Default geometry of the stack.
   localparam int SECTOR_BYTES_DEF = 256;
   localparam int NUM_SECTORS_DEF  = 16;

   // Sector payload register: width, reset value and lower clamp.
   localparam int CFG_W       = 9;
   localparam int CFG_RESET   = 256;
   localparam int MIN_PAYLOAD = 24;

   // Value path: eight byte lanes make one 64-bit value.
   localparam int VALUE_W = 64;
   localparam int LANES   = 8;
   localparam int LANE_SW = 3;
   localparam int SLACK_W = 3;

   // Action codes carried in the request tuser.
   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   // Result status codes.
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

   // Command to the byte-lane memories.
   typedef struct packed {
      logic       rd;
      logic       wr;
      logic [1:0] width_code;
   } lane_cmd_type;

endpackage

@@ hdl/sms_ram.sv @@
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with one write and one registered read port.
// Depends on nothing; used for the byte lanes and the sector slack store.

module sms_ram #(
   parameter int  DEPTH = 16,
   parameter int  WIDTH = 8,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // The read data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/sms_lanes.sv @@
`timescale 1ns / 1ps
// Eight byte-lane memories that read and write unaligned little-endian values of 1, 2, 4 or 8 bytes.
// Depends on sms_pkg and sms_ram.

module sms_lanes #(
   parameter int  STORE_BYTES = sms_pkg::SECTOR_BYTES_DEF * sms_pkg::NUM_SECTORS_DEF,
   localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1,
   localparam int ROWS        = (STORE_BYTES + sms_pkg::LANES - 1) / sms_pkg::LANES,
   localparam int RW          = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                          clock,
   input  sms_pkg::lane_cmd_type         cmd,
   input  logic [AW-1:0]                 addr,
   input  logic [sms_pkg::VALUE_W-1:0]   wdata,
   output logic [sms_pkg::VALUE_W-1:0]   rdata
);

   logic [sms_pkg::LANE_SW-1:0] first_lane;
   logic [RW-1:0]               first_row;
   logic [3:0]                  nbytes;
   logic [7:0]                  lane_rd [sms_pkg::LANES];
   logic [sms_pkg::LANE_SW-1:0] lane_ff;
   logic [1:0]                  width_ff;

   assign first_lane = addr[sms_pkg::LANE_SW-1:0];
   assign first_row  = RW'(addr >> sms_pkg::LANE_SW);
   assign nbytes     = 4'd1 << cmd.width_code;

   for (genvar l = 0; l < sms_pkg::LANES; l++) begin : g_lane
      logic [sms_pkg::LANE_SW-1:0] pos;
      logic [RW-1:0]               row;
      logic                        wr_en;

      // Byte pos of the value lands in this lane; lanes below the first one wrap to the next row.
      assign pos   = sms_pkg::LANE_SW'(l) - first_lane;
      assign row   = first_row + RW'(sms_pkg::LANE_SW'(l) < first_lane);
      assign wr_en = cmd.wr && ({1'b0, pos} < nbytes);

      sms_ram #(
         .DEPTH (ROWS),
         .WIDTH (8)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (row),
         .wr_data (wdata[{pos, 3'b000} +: 8]),
         .rd_en   (cmd.rd),
         .rd_addr (row),
         .rd_data (lane_rd[l])
      );
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         lane_ff  <= first_lane;
         width_ff <= cmd.width_code;
      end
   end

   // Rotate the lanes back into byte order and clear the bytes beyond the width.
   always_comb begin
      logic [3:0]                  rbytes;
      logic [sms_pkg::LANE_SW-1:0] src;
      rbytes = 4'd1 << width_ff;
      rdata  = '0;
      for (int i = 0; i < sms_pkg::LANES; i++) begin
         src = lane_ff + sms_pkg::LANE_SW'(i);
         if (4'(i) < rbytes) begin
            rdata[8*i +: 8] = lane_rd[src];
         end
      end
   end

endmodule

@@ hdl/segmented_multiwidth_byte_stack_unit.sv @@
`timescale 1ns / 1ps
// Top level of the segmented multi-width byte stack: sequencer, stack pointer, result register.
// Depends on sms_pkg, sms_ram and sms_lanes.

// A last-in first-out stack of 1-, 2-, 4- or 8-byte values, kept little-endian in NUM_SECTORS
// sectors of SECTOR_BYTES bytes, of which the first sector_payload bytes are used (the register
// is clamped to 24 .. SECTOR_BYTES and takes a write only while the stack is empty). Each request
// transfer yields exactly one response transfer: the popped value with status ok, zero with status
// empty for a pop that cannot be served, or zero with status overflow for a push past the last
// sector, which is dropped. The response to a push, or to a pop that is served from the current
// sector, is registered from the decide state once the output register is free, and the sequencer
// then returns to idle, ready for the next request. A pop that must step back into the previous
// sector passes through a further read state, because the slack of that sector comes from a
// memory with a registered read port and the bytes must then be read again at the restored
// offset. One item is in work at a time; a finished response may wait in the output register
// while the next request is accepted, and that request then waits for the response to leave.
// The bytes live in eight byte-lane RAMs and the sector slack counts in a small RAM; none of them
// is cleared after reset, and the block is ready for a request as soon as reset is released.

module segmented_multiwidth_byte_stack_unit #(
   parameter int SECTOR_BYTES = sms_pkg::SECTOR_BYTES_DEF,
   parameter int NUM_SECTORS  = sms_pkg::NUM_SECTORS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sms_pkg::VALUE_W-1:0]    req_tdata,  // [63:0] push_value
   input  logic [2:0]                     req_tuser,  // [0] action, [2:1] width_code
   // Response channel.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sms_pkg::VALUE_W-1:0]    rsp_tdata,  // [63:0] pop_value
   output logic [sms_pkg::STATUS_W-1:0]   rsp_tuser,  // [1:0] status
   // Sector payload register.
   input  logic                           csr_wen,
   input  logic [sms_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int STORE_BYTES = SECTOR_BYTES * NUM_SECTORS;
   localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int OW          = $clog2(SECTOR_BYTES + 1);
   localparam int IW          = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
   localparam int CW          = (OW > sms_pkg::CFG_W) ? OW : sms_pkg::CFG_W;
   localparam int PAY_RESET   = (sms_pkg::CFG_RESET < SECTOR_BYTES) ?
                                sms_pkg::CFG_RESET : SECTOR_BYTES;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECIDE = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [IW-1:0]                 index_ff, index_in;
   logic [OW-1:0]                 offset_ff, offset_in;
   logic [AW-1:0]                 base_ff, base_in;
   logic [OW-1:0]                 payload_ff;
   logic                          action_ff;
   logic [1:0]                    wcode_ff;
   logic [sms_pkg::VALUE_W-1:0]   value_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sms_pkg::VALUE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [sms_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic                          accept;
   logic                          out_free;
   logic [3:0]                    w_req;
   logic [3:0]                    w_item;
   logic                          fits;
   logic                          at_last;
   logic                          have;
   logic [OW-1:0]                 back_off;
   logic                          back_ok;
   logic [sms_pkg::SLACK_W-1:0]   slack_s;
   logic [CW-1:0]                 cfg_ext;
   logic [OW-1:0]                 cfg_clamped;

   sms_pkg::lane_cmd_type         lane_cmd;
   logic [AW-1:0]                 lane_addr;
   logic [sms_pkg::VALUE_W-1:0]   lane_rdata;
   logic                          slack_wr;
   logic                          slack_rd_en;
   logic [sms_pkg::SLACK_W-1:0]   slack_rd;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign w_req  = 4'd1 << req_tuser[2:1];
   assign w_item = 4'd1 << wcode_ff;

   // Decisions on the item in work, against the current stack pointer.
   assign fits     = ({1'b0, offset_ff} + (OW+1)'(w_item)) <= {1'b0, payload_ff};
   assign at_last  = ((IW+1)'(index_ff) + (IW+1)'(1)) >= (IW+1)'(NUM_SECTORS);
   assign have     = offset_ff >= OW'(w_item);
   assign back_off = payload_ff - OW'(slack_rd);
   assign back_ok  = back_off >= OW'(w_item);
   assign slack_s  = (payload_ff > offset_ff) ? sms_pkg::SLACK_W'(payload_ff - offset_ff) : '0;

   // The payload register is clamped as it is written.
   assign cfg_ext = CW'(csr_wdata);
   always_comb begin
      if (cfg_ext < CW'(sms_pkg::MIN_PAYLOAD)) begin
         cfg_clamped = OW'(sms_pkg::MIN_PAYLOAD);
      end else if (cfg_ext > CW'(SECTOR_BYTES)) begin
         cfg_clamped = OW'(SECTOR_BYTES);
      end else begin
         cfg_clamped = OW'(cfg_ext);
      end
   end

   // Sequencer. On acceptance the bytes just below the top and the slack of the previous sector
   // are read at once, so a pop within the sector can be answered from the decide state.
   always_comb begin
      state_in      = state_ff;
      index_in      = index_ff;
      offset_in     = offset_ff;
      base_in       = base_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      lane_cmd      = '{rd: 1'b0, wr: 1'b0, width_code: wcode_ff};
      lane_addr     = base_ff + AW'(offset_ff) - AW'(w_item);
      slack_wr      = 1'b0;
      slack_rd_en   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lane_cmd    = '{rd: 1'b1, wr: 1'b0, width_code: req_tuser[2:1]};
               lane_addr   = base_ff + AW'(offset_ff) - AW'(w_req);
               slack_rd_en = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (action_ff == sms_pkg::ACT_PUSH) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = '0;
                  state_in      = ST_IDLE;
                  if (!fits && at_last) begin
                     rsp_status_in = sms_pkg::ST_OVERFLOW;
                  end else begin
                     rsp_status_in = sms_pkg::ST_OK;
                     lane_cmd.wr   = 1'b1;
                     if (fits) begin
                        lane_addr = base_ff + AW'(offset_ff);
                        offset_in = offset_ff + OW'(w_item);
                     end else begin
                        // Close this sector with its slack and start the next one.
                        slack_wr  = 1'b1;
                        base_in   = base_ff + AW'(SECTOR_BYTES);
                        lane_addr = base_ff + AW'(SECTOR_BYTES);
                        index_in  = index_ff + IW'(1);
                        offset_in = OW'(w_item);
                     end
                  end
               end
            end else if (have) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = lane_rdata;
                  rsp_status_in = sms_pkg::ST_OK;
                  offset_in     = offset_ff - OW'(w_item);
                  state_in      = ST_IDLE;
               end
            end else if (index_ff == '0 || !back_ok) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = '0;
                  rsp_status_in = sms_pkg::ST_EMPTY;
                  state_in      = ST_IDLE;
               end
            end else begin
               // Step back into the previous sector and read again at the restored offset.
               lane_cmd.rd = 1'b1;
               lane_addr   = base_ff - AW'(SECTOR_BYTES) + AW'(back_off) - AW'(w_item);
               base_in     = base_ff - AW'(SECTOR_BYTES);
               index_in    = index_ff - IW'(1);
               offset_in   = back_off - OW'(w_item);
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = lane_rdata;
               rsp_status_in = sms_pkg::ST_OK;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         index_ff     <= '0;
         offset_ff    <= '0;
         base_ff      <= '0;
         payload_ff   <= OW'(PAY_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         index_ff     <= index_in;
         offset_ff    <= offset_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
         // The payload may only change while the stack is empty.
         if (csr_wen && index_ff == '0 && offset_ff == '0) begin
            payload_ff <= cfg_clamped;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         action_ff <= req_tuser[0];
         wcode_ff  <= req_tuser[2:1];
         value_ff  <= req_tdata;
      end
   end

   sms_lanes #(
      .STORE_BYTES (STORE_BYTES)
   ) u_lanes (
      .clock (clock),
      .cmd   (lane_cmd),
      .addr  (lane_addr),
      .wdata (value_ff),
      .rdata (lane_rdata)
   );

   sms_ram #(
      .DEPTH (NUM_SECTORS),
      .WIDTH (sms_pkg::SLACK_W)
   ) u_slack (
      .clock   (clock),
      .wr_en   (slack_wr),
      .wr_addr (index_ff),
      .wr_data (slack_s),
      .rd_en   (slack_rd_en),
      .rd_addr (index_ff - IW'(1)),
      .rd_data (slack_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef ASSERT_OFF
   // The top of the stack never lies beyond the payload of its sector.
   a_offset_in_payload: assert property (@(posedge clock) disable iff (reset)
      offset_ff <= payload_ff)
      else $error("stack offset beyond sector payload");

   // The sector base address tracks the sector index.
   a_base_tracks_index: assert property (@(posedge clock) disable iff (reset)
      base_ff == AW'(int'(index_ff) * SECTOR_BYTES))
      else $error("sector base out of step with sector index");

   // The sector index stays within the chain.
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      int'(index_ff) < NUM_SECTORS)
      else $error("sector index past the last sector");

   // An accepted request moves the sequencer into the decide state in the following cycle.
   a_accept_decides: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_DECIDE)
      else $error("accepted request not taken into work");

   // A failed request leaves the stack pointer untouched.
   a_fail_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && rsp_valid_in && rsp_status_in != sms_pkg::ST_OK)
      |=> $stable(index_ff) && $stable(offset_ff))
      else $error("failed request changed the stack pointer");
`endif

endmodule
